@@ rtl/core/mmbd_pkg.sv @@
// Shared types and codes of the memory map bank decoder.
package mmbd_pkg;

    // Access kinds
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Target codes
    localparam logic [3:0] T_PORT   = 4'd0;
    localparam logic [3:0] T_CARTLO = 4'd1;
    localparam logic [3:0] T_CARTHI = 4'd2;
    localparam logic [3:0] T_BASIC  = 4'd3;
    localparam logic [3:0] T_CHAR   = 4'd4;
    localparam logic [3:0] T_KERNAL = 4'd5;
    localparam logic [3:0] T_RAM    = 4'd6;
    localparam logic [3:0] T_VIDEO  = 4'd7;
    localparam logic [3:0] T_SOUND  = 4'd8;
    localparam logic [3:0] T_COLOUR = 4'd9;
    localparam logic [3:0] T_TIMER1 = 4'd10;
    localparam logic [3:0] T_TIMER2 = 4'd11;
    localparam logic [3:0] T_NONE   = 4'd12;
    localparam logic [3:0] T_DEBUG  = 4'd13;

    // Configuration register indexes
    localparam logic [2:0] CFG_CART_MOUNTED  = 3'd0;
    localparam logic [2:0] CFG_CART_MODE     = 3'd1;
    localparam logic [2:0] CFG_LOW_ROM       = 3'd2;
    localparam logic [2:0] CFG_HIGH_ROM      = 3'd3;
    localparam logic [2:0] CFG_DEBUG_EXIT    = 3'd4;
    localparam logic [2:0] CFG_DEVICES       = 3'd5;

    // Cartridge modes
    localparam logic [1:0] CART_NONE    = 2'd0;
    localparam logic [1:0] CART_16K     = 2'd2;
    localparam logic [1:0] CART_ULTIMAX = 2'd3;

    // Port reset values and fixed addresses
    localparam logic [7:0]  PORT_DIR_RESET = 8'h2f;
    localparam logic [7:0]  PORT_VAL_RESET = 8'h37;
    localparam logic [15:0] DEBUG_EXIT_ADDR = 16'hd7ff;
    localparam logic [7:0]  UNMAPPED_DATA  = 8'hff;

    typedef struct packed {
        logic        operation;
        logic [15:0] address;
        logic [7:0]  write_data;
    } in_word_t;

    typedef struct packed {
        logic [3:0]  target;
        logic [15:0] offset;
        logic [7:0]  data;
        logic        data_valid;
        logic        bank_refresh;
    } out_word_t;

endpackage

@@ rtl/core/memory_map_bank_decoder.sv @@
// Top level of the memory map bank decoder: access decode, port registers, configuration.
//
//  channel  direction  handshake            word
//  in       to block   in_valid / in_stall  in_data   (operation, address, write_data)
//  out      from block out_valid / out_stall out_data (target, offset, data, flags)
//  cfg      to block   cfg_valid / cfg_ready cfg_index, cfg_data
//
// One access is decoded per cycle unless out_stall holds the result: the decode runs
// straight from the accepted word into the result register, and a new word may enter
// every cycle that in_stall is low. Port writes land at the acceptance edge, so the next
// word already decodes with the new banking. rst_n clears the configuration, the
// port registers (to their power-on values) and the result valid. in_stall rises
// only while a result is held by out_stall; the result register frees in the same
// cycle it is taken. cfg_ready is always high.
module memory_map_bank_decoder
    import mmbd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [3:0] cfg_data
);

    // Configuration registers
    logic       cart_mounted_reg;
    logic [1:0] cart_mode_reg;
    logic       low_rom_reg;
    logic       high_rom_reg;
    logic       debug_exit_reg;
    logic [3:0] devices_reg;

    // Processor port
    logic [7:0] port_dir_reg,   port_dir_next;
    logic [7:0] port_val_reg,   port_val_next;

    // Result register
    logic      out_valid_reg, out_valid_next;
    out_word_t out_reg,       out_next;

    logic accept;
    logic out_free;

    // Decode helpers
    logic [15:0] a;
    logic [7:0]  wd;
    logic        io_win, io_vis, char_vis, ioc;
    logic        hit_video, hit_sound, hit_colour, hit_timer1, hit_timer2;
    logic [3:0]  io_tgt;
    logic [15:0] io_off;

    assign cfg_ready = 1'b1;
    assign out_free  = !(out_valid_reg && out_stall);
    assign in_stall  = !out_free;
    assign accept    = in_valid && out_free;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign a  = in_data.address;
    assign wd = in_data.write_data;

    assign ioc      = (port_val_reg[1:0] != 2'b00);
    assign io_vis   = ioc && port_val_reg[2];
    assign char_vis = ioc && !port_val_reg[2];
    assign io_win   = (a[15:12] == 4'hd);

    // I/O window regions, first match wins in this order
    assign hit_video  = io_win && (a[11:10] == 2'b00) && devices_reg[0];
    assign hit_sound  = io_win && (a[11:5] == 7'b0100000) && devices_reg[1];
    assign hit_colour = io_win && (a[11:10] == 2'b10);
    assign hit_timer1 = io_win && (a[11:8] == 4'hc) && devices_reg[2];
    assign hit_timer2 = io_win && (a[11:8] == 4'hd) && devices_reg[3];

    always_comb
    begin
        io_tgt = T_NONE;
        io_off = 16'h0000;
        if (hit_video)
        begin
            io_tgt = T_VIDEO;
            io_off = {6'b0, a[9:0]};
        end
        else if (hit_sound)
        begin
            io_tgt = T_SOUND;
            io_off = {11'b0, a[4:0]};
        end
        else if (hit_colour)
        begin
            io_tgt = T_COLOUR;
            io_off = {6'b0, a[9:0]};
        end
        else if (hit_timer1)
        begin
            io_tgt = T_TIMER1;
            io_off = {8'b0, a[7:0]};
        end
        else if (hit_timer2)
        begin
            io_tgt = T_TIMER2;
            io_off = {8'b0, a[7:0]};
        end
    end

    // Access decode into the result register; port writes land at the same edge
    always_comb
    begin
        port_dir_next  = port_dir_reg;
        port_val_next  = port_val_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_free)
        begin
            out_valid_next = in_valid;
        end

        if (accept)
        begin
            out_next.target       = T_RAM;
            out_next.offset       = a;
            out_next.data         = 8'h00;
            out_next.data_valid   = 1'b0;
            out_next.bank_refresh = 1'b0;

            if (in_data.operation == OP_WRITE)
            begin
                out_next.data = wd;
                if (a[15:1] == 15'b0)
                begin
                    out_next.target = T_PORT;
                    if (a[0])
                    begin
                        port_val_next = wd;
                    end
                    else
                    begin
                        port_dir_next = wd;
                    end
                end
                else if (io_win && io_vis)
                begin
                    if (a == DEBUG_EXIT_ADDR && debug_exit_reg)
                    begin
                        out_next.target = T_DEBUG;
                        out_next.offset = 16'h0000;
                    end
                    else
                    begin
                        out_next.target = io_tgt;
                        out_next.offset = io_off;
                        if (io_tgt == T_COLOUR)
                        begin
                            out_next.data = {4'b0, wd[3:0]};
                        end
                        // Timer2 port A or its direction register forces a bank refresh
                        if (io_tgt == T_TIMER2 && a[3:2] == 2'b00 && a[0] == 1'b0)
                        begin
                            out_next.bank_refresh = 1'b1;
                        end
                    end
                end
            end
            else
            begin
                if (a[15:1] == 15'b0)
                begin
                    out_next.target     = T_PORT;
                    out_next.data       = a[0] ? port_val_reg : port_dir_reg;
                    out_next.data_valid = 1'b1;
                end
                else if (cart_mounted_reg && low_rom_reg && cart_mode_reg != CART_NONE
                         && a[15:13] == 3'b100)
                begin
                    out_next.target = T_CARTLO;
                    out_next.offset = {3'b0, a[12:0]};
                end
                else if (cart_mounted_reg && high_rom_reg && cart_mode_reg == CART_16K
                         && a[15:13] == 3'b101)
                begin
                    out_next.target = T_CARTHI;
                    out_next.offset = {3'b0, a[12:0]};
                end
                else if (cart_mounted_reg && high_rom_reg && cart_mode_reg == CART_ULTIMAX
                         && a[15:13] == 3'b111)
                begin
                    out_next.target = T_CARTHI;
                    out_next.offset = {3'b0, a[12:0]};
                end
                else if (a[15:13] == 3'b101 && port_val_reg[1:0] == 2'b11)
                begin
                    out_next.target = T_BASIC;
                    out_next.offset = {3'b0, a[12:0]};
                end
                else if (io_win && io_vis)
                begin
                    out_next.target = io_tgt;
                    out_next.offset = io_off;
                    // Nothing answers here: the block drives an open bus itself
                    if (io_tgt == T_NONE)
                    begin
                        out_next.data       = UNMAPPED_DATA;
                        out_next.data_valid = 1'b1;
                    end
                end
                else if (io_win && char_vis)
                begin
                    out_next.target = T_CHAR;
                    out_next.offset = {4'b0, a[11:0]};
                end
                else if (a[15:13] == 3'b111 && port_val_reg[1])
                begin
                    out_next.target = T_KERNAL;
                    out_next.offset = {3'b0, a[12:0]};
                end
            end
        end
    end

    // Control state and port registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            port_dir_reg  <= PORT_DIR_RESET;
            port_val_reg  <= PORT_VAL_RESET;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            port_dir_reg  <= port_dir_next;
            port_val_reg  <= port_val_next;
        end
    end

    // Result payload, no reset
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // Configuration writes; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cart_mounted_reg <= 1'b0;
            cart_mode_reg    <= 2'b00;
            low_rom_reg      <= 1'b0;
            high_rom_reg     <= 1'b0;
            debug_exit_reg   <= 1'b0;
            devices_reg      <= 4'h0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CART_MOUNTED: cart_mounted_reg <= cfg_data[0];
                CFG_CART_MODE:    cart_mode_reg    <= cfg_data[1:0];
                CFG_LOW_ROM:      low_rom_reg      <= cfg_data[0];
                CFG_HIGH_ROM:     high_rom_reg     <= cfg_data[0];
                CFG_DEBUG_EXIT:   debug_exit_reg   <= cfg_data[0];
                CFG_DEVICES:      devices_reg      <= cfg_data;
                default:          ;
            endcase
        end
    end

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the memory map bank decoder: directed and random bus accesses.
`timescale 1ns / 100ps

module testbench;
    import mmbd_pkg::*;

    // The package names no 8K cartridge mode, so give it a local name
    localparam logic [1:0] CART_8K = 2'd1;

    localparam int IDLE_LIMIT           = 1000;
    localparam int RANDOM_SEGMENTS      = 9;
    localparam int ACCESSES_PER_SEGMENT = 195;
    localparam int DRAIN_CYCLES         = 20;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    in_word_t   in_data   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_word_t  out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [3:0] cfg_data  = '0;

    memory_map_bank_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Mirror of the bank configuration, updated on each accepted register write
    logic       cfg_mounted    = 1'b0;
    logic [1:0] cfg_mode       = CART_NONE;
    logic       cfg_low_rom    = 1'b0;
    logic       cfg_high_rom   = 1'b0;
    logic       cfg_debug_exit = 1'b0;
    logic [3:0] cfg_devices    = 4'h0;

    // Mirror of the processor port registers at addresses 0 and 1
    logic [7:0] port_dir_model = PORT_DIR_RESET;
    logic [7:0] port_val_model = PORT_VAL_RESET;

    in_word_t  pending_accesses [$];
    out_word_t expected_decodes [$];

    // Region edges of the memory map, where off-by-one decode faults hide
    logic [15:0] boundary_addrs [$] = '{
        16'h0000, 16'h0001, 16'h0002, 16'h7fff, 16'h8000, 16'h9fff, 16'ha000,
        16'hbfff, 16'hc000, 16'hcfff, 16'hd000, 16'hd3ff, 16'hd400, 16'hd41f,
        16'hd420, 16'hd7fe, 16'hd7ff, 16'hd800, 16'hdbff, 16'hdc00, 16'hdcff,
        16'hdd00, 16'hddff, 16'hde00, 16'hdfff, 16'he000, 16'hffff
    };

    int          mismatch_count   = 0;
    int          accesses_decoded = 0;
    int          reads_decoded    = 0;
    int          writes_decoded   = 0;
    int          bank_settings    = 0;
    int          idle_cycles      = 0;
    int          send_idle_pct    = 11;
    int          recv_idle_pct    = 51;
    logic [15:0] targets_seen     = '0;
    bit          word_taken       = 1'b0;

    // Invert the clock every half period: 10 ns cycle
    always #5 clk = ~clk;

    // Print one line per mismatch and count every one
    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Decode one bus access as the block should, and advance the port mirror on port writes
    function automatic out_word_t decode_access(input in_word_t acc);
        out_word_t   r;
        logic [15:0] a;
        logic [15:0] io_off;
        logic [3:0]  io_tgt;
        logic        io_vis;
        logic        char_vis;
        logic        in_io_window;
        a            = acc.address;
        io_vis       = (port_val_model[1:0] != 2'b00) && port_val_model[2];
        char_vis     = (port_val_model[1:0] != 2'b00) && !port_val_model[2];
        in_io_window = (a >= 16'hd000) && (a <= 16'hdfff);

        // Resolve the I/O window first; absent devices fall through to unmapped
        io_off = 16'd0;
        io_tgt = T_NONE;
        if (a >= 16'hd000 && a <= 16'hd3ff && cfg_devices[0])
        begin
            io_tgt = T_VIDEO;
            io_off = a - 16'hd000;
        end
        else if (a >= 16'hd400 && a <= 16'hd41f && cfg_devices[1])
        begin
            io_tgt = T_SOUND;
            io_off = a - 16'hd400;
        end
        else if (a >= 16'hd800 && a <= 16'hdbff)
        begin
            io_tgt = T_COLOUR;
            io_off = a - 16'hd800;
        end
        else if (a >= 16'hdc00 && a <= 16'hdcff && cfg_devices[2])
        begin
            io_tgt = T_TIMER1;
            io_off = a - 16'hdc00;
        end
        else if (a >= 16'hdd00 && a <= 16'hddff && cfg_devices[3])
        begin
            io_tgt = T_TIMER2;
            io_off = a - 16'hdd00;
        end

        r.target       = T_RAM;
        r.offset       = a;
        r.data         = 8'h00;
        r.data_valid   = 1'b0;
        r.bank_refresh = 1'b0;

        if (acc.operation == OP_WRITE)
        begin
            // Writes ignore cartridge and ROM visibility: they land in RAM beneath
            r.data = acc.write_data;
            if (a <= 16'd1)
            begin
                r.target = T_PORT;
                if (a == 16'd0)
                    port_dir_model = acc.write_data;
                else
                    port_val_model = acc.write_data;
            end
            else if (in_io_window && io_vis)
            begin
                if (a == DEBUG_EXIT_ADDR && cfg_debug_exit)
                begin
                    r.target = T_DEBUG;
                    r.offset = 16'd0;
                end
                else
                begin
                    r.target = io_tgt;
                    r.offset = io_off;
                    if (io_tgt == T_COLOUR)
                        r.data = {4'h0, acc.write_data[3:0]};
                    if (io_tgt == T_TIMER2 && (a[3:0] == 4'h0 || a[3:0] == 4'h2))
                        r.bank_refresh = 1'b1;
                end
            end
        end
        else
        begin
            if (a <= 16'd1)
            begin
                r.target     = T_PORT;
                r.data       = (a == 16'd0) ? port_dir_model : port_val_model;
                r.data_valid = 1'b1;
            end
            else if (cfg_mounted && cfg_low_rom && cfg_mode != CART_NONE &&
                     a >= 16'h8000 && a <= 16'h9fff)
            begin
                r.target = T_CARTLO;
                r.offset = a - 16'h8000;
            end
            else if (cfg_mounted && cfg_high_rom && cfg_mode == CART_16K &&
                     a >= 16'ha000 && a <= 16'hbfff)
            begin
                r.target = T_CARTHI;
                r.offset = a - 16'ha000;
            end
            else if (cfg_mounted && cfg_high_rom && cfg_mode == CART_ULTIMAX &&
                     a >= 16'he000)
            begin
                r.target = T_CARTHI;
                r.offset = a - 16'he000;
            end
            else if (a >= 16'ha000 && a <= 16'hbfff && port_val_model[1:0] == 2'b11)
            begin
                r.target = T_BASIC;
                r.offset = a - 16'ha000;
            end
            else if (in_io_window && io_vis)
            begin
                r.target = io_tgt;
                r.offset = io_off;
                if (io_tgt == T_NONE)
                begin
                    r.data       = UNMAPPED_DATA;
                    r.data_valid = 1'b1;
                end
            end
            else if (in_io_window && char_vis)
            begin
                r.target = T_CHAR;
                r.offset = a - 16'hd000;
            end
            else if (a >= 16'he000 && port_val_model[1])
            begin
                r.target = T_KERNAL;
                r.offset = a - 16'he000;
            end
        end
        return r;
    endfunction

    // Monitor: sample both handshakes at the rising edge, predict on input, check on output
    always @(posedge clk)
    begin
        out_word_t want;
        bit        result_taken;
        if (rst_n)
        begin
            word_taken   = in_valid && !in_stall;
            result_taken = out_valid && !out_stall;

            // Predict at acceptance so that port writes bank the very next word
            if (word_taken)
            begin
                want = decode_access(in_data);
                expected_decodes.push_back(want);
                targets_seen[want.target] = 1'b1;
                accesses_decoded++;
                if (in_data.operation == OP_WRITE)
                    writes_decoded++;
                else
                    reads_decoded++;
            end

            // Compare each taken result with the oldest prediction, field by field
            if (result_taken)
            begin
                if (expected_decodes.size() == 0)
                    report_mismatch($sformatf("result with no access pending: target %0d offset %h",
                                              out_data.target, out_data.offset));
                else
                begin
                    want = expected_decodes.pop_front();
                    if (out_data.target !== want.target)
                        report_mismatch($sformatf("target %0d, expected %0d (offset %h)",
                                                  out_data.target, want.target, want.offset));
                    if (out_data.offset !== want.offset)
                        report_mismatch($sformatf("offset %h, expected %h (target %0d)",
                                                  out_data.offset, want.offset, want.target));
                    if (out_data.data !== want.data)
                        report_mismatch($sformatf("data %h, expected %h (target %0d offset %h)",
                                                  out_data.data, want.data, want.target,
                                                  want.offset));
                    if (out_data.data_valid !== want.data_valid)
                        report_mismatch($sformatf("data_valid %b, expected %b (target %0d)",
                                                  out_data.data_valid, want.data_valid,
                                                  want.target));
                    if (out_data.bank_refresh !== want.bank_refresh)
                        report_mismatch($sformatf("bank_refresh %b, expected %b (offset %h)",
                                                  out_data.bank_refresh, want.bank_refresh,
                                                  want.offset));
                end
            end

            // Feed the watchdog: any accepted word on any channel counts as progress
            if (word_taken || result_taken || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // Driver: change inputs at the falling edge; hold a word until it is taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || word_taken)
            begin
                if (pending_accesses.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_data  <= pending_accesses.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // End the run when nothing moves for too long
    initial
    begin : watchdog
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("Watchdog: no word accepted for %0d cycles", IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    task automatic queue_access(input logic op, input logic [15:0] addr, input logic [7:0] wdata);
        in_word_t w;
        w.operation  = op;
        w.address    = addr;
        w.write_data = wdata;
        pending_accesses.push_back(w);
    endtask

    // Build one random access, leaning on port rebanking and the busy regions of the map
    task automatic queue_random_access();
        int          pick;
        logic [15:0] addr;
        pick = $urandom_range(99);
        if (pick < 8)
            queue_access(OP_WRITE, 16'h0001, 8'($urandom));
        else if (pick < 11)
            queue_access(1'($urandom_range(1)), 16'h0000, 8'($urandom));
        else
        begin
            case ($urandom_range(8))
                0:       addr = 16'($urandom);
                1:       addr = boundary_addrs[$urandom_range(boundary_addrs.size() - 1)];
                2:       addr = 16'h8000 | 16'($urandom_range(16'h3fff));
                3:       addr = 16'hd000 | 16'($urandom_range(16'h0fff));
                4:       addr = 16'he000 | 16'($urandom_range(16'h1fff));
                5:       addr = 16'hdd00 | 16'($urandom_range(15));
                6:       addr = DEBUG_EXIT_ADDR;
                7:       addr = 16'hd400 | 16'($urandom_range(63));
                default: addr = 16'($urandom_range(1));
            endcase
            queue_access(1'($urandom_range(1)), addr, 8'($urandom));
        end
    endtask

    // Write one register and track it in the mirror once the handshake completes
    task automatic write_register(input logic [2:0] index, input logic [3:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (index)
            CFG_CART_MOUNTED: cfg_mounted    = value[0];
            CFG_CART_MODE:    cfg_mode       = value[1:0];
            CFG_LOW_ROM:      cfg_low_rom    = value[0];
            CFG_HIGH_ROM:     cfg_high_rom   = value[0];
            CFG_DEBUG_EXIT:   cfg_debug_exit = value[0];
            CFG_DEVICES:      cfg_devices    = value;
            default:          ;
        endcase
    endtask

    // Program a full bank setting; pad each value with junk above the register width
    // and finish with a write to an index past the end, both of which must be ignored
    task automatic program_bank(input logic mounted, input logic [1:0] mode,
                                input logic low_rom, input logic high_rom,
                                input logic debug_exit, input logic [3:0] devices);
        write_register(CFG_CART_MOUNTED, {3'($urandom), mounted});
        write_register(CFG_CART_MODE, {2'($urandom), mode});
        write_register(CFG_LOW_ROM, {3'($urandom), low_rom});
        write_register(CFG_HIGH_ROM, {3'($urandom), high_rom});
        write_register(CFG_DEBUG_EXIT, {3'($urandom), debug_exit});
        write_register(CFG_DEVICES, devices);
        write_register(CFG_DEVICES + 3'd1 + 3'($urandom_range(1)), 4'($urandom));
        @(negedge clk);
        cfg_valid <= 1'b0;
        bank_settings++;
    endtask

    // Wait until every queued access has been taken and every result checked
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_accesses.size() != 0 || in_valid || expected_decodes.size() != 0);
    endtask

    initial
    begin : stimulus
        int seg;

        // Hold reset, then release it once for the whole run
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: 16K cartridge, every device, debug exit armed, reset banking
        program_bank(1'b1, CART_16K, 1'b1, 1'b1, 1'b1, 4'hf);
        queue_access(OP_READ,  16'h0000, 8'h00);   // direction at power-on value
        queue_access(OP_READ,  16'h0001, 8'hff);   // port value at power-on value
        queue_access(OP_READ,  16'h8000, 8'h00);   // cartridge low ROM
        queue_access(OP_READ,  16'hbfff, 8'h00);   // cartridge high ROM over BASIC
        queue_access(OP_READ,  16'he000, 8'h00);   // kernal
        queue_access(OP_READ,  16'hd000, 8'h00);   // video
        queue_access(OP_READ,  16'hd41f, 8'h00);   // last sound register
        queue_access(OP_READ,  16'hd420, 8'h00);   // unmapped hole answers by itself
        queue_access(OP_WRITE, 16'hdbff, 8'hab);   // colour RAM keeps the low nibble
        queue_access(OP_WRITE, 16'hdd00, 8'h5c);   // timer2 port A: bank refresh
        queue_access(OP_WRITE, 16'hdd02, 8'h3f);   // timer2 direction: bank refresh
        queue_access(OP_WRITE, 16'hdd0f, 8'h01);   // other timer2 register: no refresh
        queue_access(OP_WRITE, 16'hd7ff, 8'h5a);   // debug exit cell
        queue_access(OP_READ,  16'hd7ff, 8'h00);   // read of the cell is plain I/O
        queue_access(OP_WRITE, 16'ha000, 8'h77);   // write falls through to RAM
        queue_access(OP_WRITE, 16'h0000, 8'hff);
        queue_access(OP_WRITE, 16'h0001, 8'h00);   // bank everything out
        queue_access(OP_READ,  16'hd000, 8'h00);   // now RAM
        queue_access(OP_WRITE, 16'h0001, 8'h33);   // character ROM in, I/O out
        queue_access(OP_READ,  16'hd000, 8'h00);
        queue_access(OP_WRITE, 16'hd000, 8'hc4);   // write under character ROM is RAM
        wait_drained();

        // Directed: ultimax cartridge, no devices, debug exit disarmed
        program_bank(1'b1, CART_ULTIMAX, 1'b1, 1'b1, 1'b0, 4'h0);
        queue_access(OP_WRITE, 16'h0001, 8'h37);
        queue_access(OP_READ,  16'hffff, 8'h00);   // ultimax high ROM over kernal
        queue_access(OP_READ,  16'h9fff, 8'h00);
        queue_access(OP_READ,  16'ha000, 8'h00);   // BASIC: high ROM sits elsewhere
        queue_access(OP_READ,  16'hd000, 8'h00);   // absent video is unmapped
        queue_access(OP_WRITE, 16'hd7ff, 8'h11);   // disarmed cell: discarded write
        queue_access(OP_READ,  16'hd800, 8'h00);   // colour RAM is always fitted
        wait_drained();

        // Random: three idling profiles, three bank settings each, extremes first
        for (seg = 0; seg < RANDOM_SEGMENTS; seg++)
        begin
            if (seg > 0)
                wait_drained();
            send_idle_pct = (seg < 3) ? 11 : (seg < 6) ? 51 : 0;
            recv_idle_pct = (seg < 3) ? 51 : (seg < 6) ? 11 : 0;
            if (seg == 0)
                program_bank(1'b0, CART_NONE, 1'b0, 1'b0, 1'b0, 4'h0);
            else if (seg == 1)
                program_bank(1'b1, CART_ULTIMAX, 1'b1, 1'b1, 1'b1, 4'hf);
            else if (seg == 2)
                program_bank(1'b1, CART_8K, 1'b1, 1'b1, 1'b1, 4'h5);
            else
                program_bank($urandom_range(3) != 0, 2'($urandom_range(3)),
                             1'($urandom_range(1)), 1'($urandom_range(1)),
                             1'($urandom_range(1)), 4'($urandom_range(15)));
            repeat (ACCESSES_PER_SEGMENT) queue_random_access();
        end

        // Drain, then keep clocking for DRAIN_CYCLES to catch any stray result
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d bus accesses (%0d reads, %0d writes) under %0d bank settings.",
                 accesses_decoded, reads_decoded, writes_decoded, bank_settings);
        $display("Decode targets reached (bit per target code): %b", targets_seen);
        if (mismatch_count == 0 && expected_decodes.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
